FILE: hdl/hrwt_pkg.sv
package hrwt_pkg;

  localparam int WIN_W      = 8;
  localparam int PCT_W      = 7;
  localparam int FILL_W     = 8;
  localparam int HITS_W     = 8;
  localparam int CD_W       = 8;
  localparam int PROD_W     = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HIT_PCT = 8'd1;

  localparam logic [WIN_W-1:0]  WINDOW_SIZE_RST = 8'd100;
  localparam logic [PCT_W-1:0]  MIN_HIT_PCT_RST = 7'd10;
  localparam logic [PROD_W-1:0] PCT_SCALE       = 16'd100;

  localparam logic [HITS_W-1:0] HITS_MAX = '1;
  localparam logic [CD_W-1:0]   CD_MAX   = '1;

  typedef struct packed {
    logic              lookup_used;
    logic              take_hit;
    logic              suspend_started;
    logic              resumed_now;
    logic [HITS_W-1:0] hits_in_window;
  } result_t;

endpackage

FILE: hdl/hrwt_in_if.sv
interface hrwt_in_if;
  logic valid;
  logic ready;
  logic lookup_hit;

  modport source (output valid, output lookup_hit, input ready);
  modport sink (input valid, input lookup_hit, output ready);
endinterface

FILE: hdl/hrwt_out_if.sv
interface hrwt_out_if;
  logic                        valid;
  logic                        ready;
  logic                        lookup_used;
  logic                        take_hit;
  logic                        suspend_started;
  logic                        resumed_now;
  logic [hrwt_pkg::HITS_W-1:0] hits_in_window;

  modport source (
    output valid, output lookup_used, output take_hit, output suspend_started,
    output resumed_now, output hits_in_window, input ready
  );
  modport sink (
    input valid, input lookup_used, input take_hit, input suspend_started,
    input resumed_now, input hits_in_window, output ready
  );
endinterface

FILE: hdl/hrwt_cfg_if.sv
interface hrwt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hrwt_pkg::CFG_IDX_W-1:0]  index;
  logic [hrwt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/hrwt_ram.sv
module hrwt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/hit_rate_window_throttle_unit.sv
// Hit-rate throttle for a secondary cache: one lookup item in, one result item out. The
// block keeps the hit bits of the last W used lookups (W = window_size, 0 taken as 1,
// capped at MAX_WINDOW); a used miss with a full window and hits*100 < W*min_hit_pct
// suspends it, after which W-1 lookups are skipped and the W-th clears the window and is
// used again. An item is accepted every cycle while the output buffer has room and the ring
// read is aligned; each result is registered into a two-entry output buffer, so input keeps
// flowing while one result waits. The ring of hit bits is a single-port-read memory read
// one item ahead; after a write to window_size that moves the ring position, the next item
// waits while that read realigns. min_hit_pct of 0 disables suspension.
module hit_rate_window_throttle_unit #(
  parameter int MAX_WINDOW = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  hrwt_in_if.sink           in_chan,
  hrwt_out_if.source        out_chan,
  hrwt_cfg_if.sink          cfg_chan
);

  localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [hrwt_pkg::WIN_W-1:0]  win_cfg_r;
  logic [hrwt_pkg::PCT_W-1:0]  pct_cfg_r;
  logic [PW-1:0]               pos_r;
  logic [hrwt_pkg::FILL_W-1:0] fill_r;
  logic [hrwt_pkg::HITS_W-1:0] hits_r;
  logic                        susp_r;
  logic [hrwt_pkg::CD_W-1:0]   cd_r;
  logic [PW-1:0]               rd_addr_r;
  logic                        wr_valid_r;
  logic [PW-1:0]               wr_addr_r;
  logic                        wr_bit_r;
  hrwt_pkg::result_t           main_r;
  hrwt_pkg::result_t           skid_r;
  logic                        main_valid_r;
  logic                        skid_valid_r;

  logic [hrwt_pkg::WIN_W-1:0]  w;
  logic [PW-1:0]               eff_pos;
  logic                        aligned;
  logic                        accept;
  logic                        out_fire;
  logic                        ram_q;
  logic                        ring_bit;
  logic [hrwt_pkg::CD_W-1:0]   cd_inc;
  logic                        resume;
  logic                        do_update;
  logic [PW-1:0]               p;
  logic [PW-1:0]               p_nxt;
  logic [hrwt_pkg::FILL_W-1:0] f;
  logic [hrwt_pkg::FILL_W-1:0] f_nxt;
  logic [hrwt_pkg::HITS_W-1:0] h;
  logic [hrwt_pkg::HITS_W-1:0] h_dec;
  logic [hrwt_pkg::HITS_W-1:0] h_nxt;
  logic                        full;
  logic                        start;
  logic [PW-1:0]               rd_addr;
  hrwt_pkg::result_t           res;

  // effective window
  always_comb begin
    if (win_cfg_r == '0) begin
      w = hrwt_pkg::WIN_W'(1);
    end else if (32'(win_cfg_r) > 32'(MAX_WINDOW)) begin
      w = hrwt_pkg::WIN_W'(MAX_WINDOW);
    end else begin
      w = win_cfg_r;
    end
  end

  assign eff_pos  = (32'(pos_r) >= 32'(w)) ? '0 : pos_r;
  assign aligned  = (rd_addr_r == eff_pos);
  assign in_chan.ready = !skid_valid_r && aligned;
  assign accept   = in_chan.valid && in_chan.ready;
  assign out_fire = main_valid_r && out_chan.ready;
  assign ring_bit = (wr_valid_r && (wr_addr_r == rd_addr_r)) ? wr_bit_r : ram_q;

  always_comb begin
    cd_inc    = (cd_r != hrwt_pkg::CD_MAX) ? cd_r + hrwt_pkg::CD_W'(1) : cd_r;
    resume    = susp_r && (cd_inc >= hrwt_pkg::CD_W'(w));
    do_update = accept && (!susp_r || resume);

    p = resume ? '0 : eff_pos;
    f = resume ? '0 : fill_r;
    h = resume ? '0 : hits_r;

    full  = (f >= hrwt_pkg::FILL_W'(w));
    f_nxt = full ? hrwt_pkg::FILL_W'(w) : f + hrwt_pkg::FILL_W'(1);
    h_dec = (full && ring_bit && (h != '0)) ? h - hrwt_pkg::HITS_W'(1) : h;
    h_nxt = (in_chan.lookup_hit && (h_dec != hrwt_pkg::HITS_MAX)) ?
            h_dec + hrwt_pkg::HITS_W'(1) : h_dec;
    p_nxt = ((32'(p) + 32'd1) >= 32'(w)) ? '0 : p + PW'(1);

    start = !in_chan.lookup_hit && (pct_cfg_r != '0) && (f_nxt == hrwt_pkg::FILL_W'(w)) &&
            ((hrwt_pkg::PROD_W'(h_nxt) * hrwt_pkg::PCT_SCALE) <
             (hrwt_pkg::PROD_W'(w) * hrwt_pkg::PROD_W'(pct_cfg_r)));

    rd_addr = do_update ? p_nxt : eff_pos;

    if (susp_r && !resume) begin
      res.lookup_used     = 1'b0;
      res.take_hit        = 1'b0;
      res.suspend_started = 1'b0;
      res.resumed_now     = 1'b0;
      res.hits_in_window  = hits_r;
    end else begin
      res.lookup_used     = 1'b1;
      res.take_hit        = in_chan.lookup_hit;
      res.suspend_started = start;
      res.resumed_now     = resume;
      res.hits_in_window  = h_nxt;
    end
  end

  hrwt_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (do_update),
    .waddr (p),
    .wdata (in_chan.lookup_hit),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // configuration
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cfg_r <= hrwt_pkg::WINDOW_SIZE_RST;
      pct_cfg_r <= hrwt_pkg::MIN_HIT_PCT_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        hrwt_pkg::REG_WINDOW_SIZE: win_cfg_r <= cfg_chan.data[hrwt_pkg::WIN_W-1:0];
        hrwt_pkg::REG_MIN_HIT_PCT: pct_cfg_r <= cfg_chan.data[hrwt_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      fill_r     <= '0;
      hits_r     <= '0;
      susp_r     <= 1'b0;
      cd_r       <= '0;
      rd_addr_r  <= '0;
      wr_valid_r <= 1'b0;
    end else begin
      rd_addr_r  <= rd_addr;
      wr_valid_r <= do_update;
      if (accept) begin
        if (do_update) begin
          pos_r  <= p_nxt;
          fill_r <= f_nxt;
          hits_r <= h_nxt;
          susp_r <= start;
          cd_r   <= '0;
        end else begin
          cd_r <= cd_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= p;
    wr_bit_r  <= in_chan.lookup_hit;
  end

  // two-entry result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || out_fire) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || out_fire) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
      end else if (accept) begin
        main_r <= res;
      end
    end else if (accept) begin
      skid_r <= res;
    end
  end

  assign out_chan.valid           = main_valid_r;
  assign out_chan.lookup_used     = main_r.lookup_used;
  assign out_chan.take_hit        = main_r.take_hit;
  assign out_chan.suspend_started = main_r.suspend_started;
  assign out_chan.resumed_now     = main_r.resumed_now;
  assign out_chan.hits_in_window  = main_r.hits_in_window;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int MAX_WIN      = 128;
  localparam int IDLE_LIMIT   = 500;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 60;

  // expected hit-rate throttle behaviour
  class lookup_scoreboard;
    bit                                ring[MAX_WIN];
    bit                                written[MAX_WIN];
    int unsigned                       pos;
    int unsigned                       fill;
    int unsigned                       hits;
    int unsigned                       cooldown;
    bit                                susp;
    logic [hrwt_pkg::WIN_W-1:0]        win_reg;
    logic [hrwt_pkg::PCT_W-1:0]        pct_reg;
    hrwt_pkg::result_t                 expected_q[$];
    int                                errors;

    function new();
      win_reg = hrwt_pkg::WINDOW_SIZE_RST;
      pct_reg = hrwt_pkg::MIN_HIT_PCT_RST;
    endfunction

    function int unsigned eff_window(logic [hrwt_pkg::WIN_W-1:0] val);
      if (val == 0) return 1;
      if (val > MAX_WIN) return MAX_WIN;
      return 32'(val);
    endfunction

    // a resize must never lead to a read of a ring entry that was never written
    function bit can_resize(logic [hrwt_pkg::WIN_W-1:0] val);
      if (susp || fill == 0) return 1'b1;
      for (int i = 0; i < eff_window(val); i++) begin
        if (!written[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [hrwt_pkg::CFG_IDX_W-1:0] idx,
                            logic [hrwt_pkg::CFG_DATA_W-1:0] data);
      if (idx == hrwt_pkg::REG_WINDOW_SIZE) begin
        win_reg = data;
      end else if (idx == hrwt_pkg::REG_MIN_HIT_PCT) begin
        pct_reg = data[hrwt_pkg::PCT_W-1:0];
      end
    endfunction

    function void note_lookup(logic hit);
      int unsigned       w;
      hrwt_pkg::result_t r;
      w = eff_window(win_reg);
      r = '0;
      if (susp) begin
        if (cooldown < hrwt_pkg::CD_MAX) cooldown++;
        if (cooldown >= w) begin
          susp          = 1'b0;
          cooldown      = 0;
          pos           = 0;
          fill          = 0;
          hits          = 0;
          r.resumed_now = 1'b1;
        end else begin
          r.hits_in_window = hrwt_pkg::HITS_W'(hits);
          expected_q = {expected_q, r};
          return;
        end
      end
      if (pos >= w) pos = 0;
      if (fill >= w) begin
        fill = w;
        if (ring[pos] && hits > 0) hits--;
      end else begin
        fill++;
      end
      ring[pos]    = hit;
      written[pos] = 1'b1;
      if (hit && hits < hrwt_pkg::HITS_MAX) hits++;
      pos++;
      if (pos >= w) pos = 0;
      if (!hit && pct_reg != 0 && fill == w && hits * hrwt_pkg::PCT_SCALE < w * pct_reg) begin
        susp              = 1'b1;
        cooldown          = 0;
        r.suspend_started = 1'b1;
      end
      r.lookup_used    = 1'b1;
      r.take_hit       = hit;
      r.hits_in_window = hrwt_pkg::HITS_W'(hits);
      expected_q = {expected_q, r};
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_result(hrwt_pkg::result_t got);
      hrwt_pkg::result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result item with none expected");
        return;
      end
      want = expected_q.pop_front();
      if (got.lookup_used !== want.lookup_used)
        report_mismatch($sformatf("lookup_used %b, expected %b", got.lookup_used,
                                  want.lookup_used));
      if (got.take_hit !== want.take_hit)
        report_mismatch($sformatf("take_hit %b, expected %b", got.take_hit, want.take_hit));
      if (got.suspend_started !== want.suspend_started)
        report_mismatch($sformatf("suspend_started %b, expected %b", got.suspend_started,
                                  want.suspend_started));
      if (got.resumed_now !== want.resumed_now)
        report_mismatch($sformatf("resumed_now %b, expected %b", got.resumed_now,
                                  want.resumed_now));
      if (got.hits_in_window !== want.hits_in_window)
        report_mismatch($sformatf("hits_in_window %0d, expected %0d", got.hits_in_window,
                                  want.hits_in_window));
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   calm      = 1'b0;
  bit   long_hold = 1'b0;
  int   idle_cycles;

  lookup_scoreboard sb;

  hrwt_in_if  in_chan ();
  hrwt_out_if out_chan ();
  hrwt_cfg_if cfg_chan ();

  hit_rate_window_throttle_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_lookup(logic hit);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.lookup_hit <= hit;
    do @(posedge clk); while (!(in_chan.valid && in_chan.ready));
  endtask

  task automatic send_bits(logic [15:0] bits, int n);
    for (int k = 0; k < n; k++) send_lookup(bits[k]);
    in_chan.valid <= 1'b0;
  endtask

  task automatic send_random(int n, int hit_pct);
    for (int k = 0; k < n; k++) send_lookup($urandom_range(0, 99) < hit_pct);
    in_chan.valid <= 1'b0;
  endtask

  task automatic write_cfg(logic [hrwt_pkg::CFG_DATA_W-1:0] win,
                           logic [hrwt_pkg::CFG_DATA_W-1:0] pct);
    if (!sb.can_resize(win)) win = sb.win_reg;
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= hrwt_pkg::REG_WINDOW_SIZE;
    cfg_chan.data  <= win;
    do @(posedge clk); while (!(cfg_chan.valid && cfg_chan.ready));
    cfg_chan.index <= hrwt_pkg::REG_MIN_HIT_PCT;
    cfg_chan.data  <= pct;
    do @(posedge clk); while (!(cfg_chan.valid && cfg_chan.ready));
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side back-pressure
  initial begin
    forever begin
      if (long_hold) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready)
        sb.check_result(hrwt_pkg::result_t'{out_chan.lookup_used, out_chan.take_hit,
                                            out_chan.suspend_started, out_chan.resumed_now,
                                            out_chan.hits_in_window});
      if (in_chan.valid && in_chan.ready) sb.note_lookup(in_chan.lookup_hit);
      if (cfg_chan.valid && cfg_chan.ready) sb.write_reg(cfg_chan.index, cfg_chan.data);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    logic [hrwt_pkg::CFG_DATA_W-1:0] win;
    logic [hrwt_pkg::CFG_DATA_W-1:0] pct;
    sb                  = new();
    idle_cycles         = 0;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.lookup_hit <= 1'b0;
    cfg_chan.valid     <= 1'b0;
    cfg_chan.index     <= hrwt_pkg::REG_WINDOW_SIZE;
    cfg_chan.data      <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings
    send_bits(16'b101, 3);
    wait_drain();
    // window of one, resume and suspend on the same item
    write_cfg(8'd1, 8'd127);
    send_bits(16'b0011000, 7);
    wait_drain();
    // window of zero, suspension disabled
    write_cfg(8'd0, 8'd0);
    send_bits(16'b01, 2);
    wait_drain();
    write_cfg(8'd2, 8'd100);
    send_bits(16'b00001, 5);
    wait_drain();
    // window above bound, set while suspended
    write_cfg(8'd255, 8'hFF);
    send_random(280, 60);
    wait_drain();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 8) calm = 1'b1;
      case ($urandom_range(0, 9))
        0:       win = 8'd0;
        1:       win = 8'd255;
        2:       win = 8'd128;
        3:       win = hrwt_pkg::CFG_DATA_W'($urandom_range(129, 254));
        default: win = hrwt_pkg::CFG_DATA_W'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 5))
        0:       pct = 8'd0;
        1:       pct = 8'd127;
        default: pct = hrwt_pkg::CFG_DATA_W'($urandom_range(0, 255));
      endcase
      write_cfg(win, pct);
      if (ph == 3) long_hold = 1'b1;
      send_random(45, $urandom_range(0, 100));
      wait_drain();
    end

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
